// ===== rtl/ccc_pkg.sv =====
// shared types, constants and the direction table of the contour chain coder
`timescale 1ns / 1ps
`default_nettype none
package ccc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int GROUP_DEF      = 5;
	localparam int MAX_SPAN_DEF   = 64;

	// sized for the largest allowed span of 64
	localparam int SPAN_W = 7;
	localparam int LERR_W = SPAN_W + 2;

	// freeman code by 3 * sy + sx + 4, the centre entry never occurs
	localparam logic [2:0] DIR_TABLE [9] = '{
		3'd5, 3'd6, 3'd7, 3'd4, 3'd0, 3'd0, 3'd3, 3'd2, 3'd1
	};

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_CODE
	} ccc_front_state_t;

	// one segment between two successive points
	typedef struct packed {
		logic              span_err;
		logic              x_major;
		logic              xs_neg;
		logic              ys_neg;
		logic [SPAN_W-1:0] adx;
		logic [SPAN_W-1:0] ady;
	} ccc_seg_t;

	function automatic logic [2:0] dir_code(input logic signed [1:0] sx,
		input logic signed [1:0] sy);
		int idx;
		idx = 3 * int'(sy) + int'(sx) + 4;
		return DIR_TABLE[idx[3:0]];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ccc_front.sv =====
// front end: point intake, group averaging and segment setup
`timescale 1ns / 1ps
`default_nettype none
module ccc_front #(
	parameter int COORD_BITS = ccc_pkg::COORD_BITS_DEF,
	parameter int GROUP      = ccc_pkg::GROUP_DEF,
	parameter int MAX_SPAN   = ccc_pkg::MAX_SPAN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] x_coord,
	input  wire logic [COORD_BITS-1:0] y_coord,
	input  wire logic                  end_of_contour,
	output logic                       seg_valid,
	input  wire logic                  seg_ready,
	output ccc_pkg::ccc_seg_t          seg
);

	localparam int GW = $clog2(GROUP + 1);
	localparam int SW = COORD_BITS + $clog2(GROUP);
	localparam int IW = $clog2(SW + 1);
	localparam int CW = COORD_BITS + 1;

	ccc_pkg::ccc_front_state_t state_q, state_d;

	logic                  mean_mode_q;
	logic                  end_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [COORD_BITS-1:0] pt_x_q, pt_y_q;
	logic [SW-1:0]         sum_x_q, sum_y_q;
	logic [GW-1:0]         cnt_q;
	logic [SW-1:0]         div_x_q, div_y_q;
	logic [GW-1:0]         rem_x_q, rem_y_q;
	logic [GW-1:0]         div_d_q;
	logic [IW-1:0]         it_q;

	logic [SW-1:0] sum_nx, sum_ny;
	logic [GW-1:0] cnt_n;
	logic          trig;
	logic          accept;

	logic [GW:0]   trial_x, trial_y;
	logic          qbit_x, qbit_y;
	logic [GW-1:0] rem_nx, rem_ny;
	logic [SW-1:0] div_nx, div_ny;
	logic          div_last;

	logic signed [CW-1:0] dx, dy;
	logic [COORD_BITS-1:0] adx, ady, span;
	logic                  x_major;
	logic                  push_need;
	logic                  code_done;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// group accumulation
	assign sum_nx = sum_x_q + SW'(x_coord);
	assign sum_ny = sum_y_q + SW'(y_coord);
	assign cnt_n  = cnt_q + GW'(1);
	assign trig   = (cnt_n >= GW'(GROUP)) || end_of_contour;

	// one restoring divide step per cycle, x and y side by side
	assign trial_x = {rem_x_q, div_x_q[SW-1]};
	assign trial_y = {rem_y_q, div_y_q[SW-1]};
	assign qbit_x  = trial_x >= {1'b0, div_d_q};
	assign qbit_y  = trial_y >= {1'b0, div_d_q};
	assign rem_nx  = qbit_x ? GW'(trial_x - {1'b0, div_d_q}) : GW'(trial_x);
	assign rem_ny  = qbit_y ? GW'(trial_y - {1'b0, div_d_q}) : GW'(trial_y);
	assign div_nx  = {div_x_q[SW-2:0], qbit_x};
	assign div_ny  = {div_y_q[SW-2:0], qbit_y};
	assign div_last = it_q == IW'(1);

	// segment from the previous point
	assign dx = signed'({1'b0, pt_x_q}) - signed'({1'b0, prev_x_q});
	assign dy = signed'({1'b0, pt_y_q}) - signed'({1'b0, prev_y_q});
	assign adx = dx[CW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
	assign ady = dy[CW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
	assign x_major = adx > ady;
	assign span    = x_major ? adx : ady;
	assign push_need = have_prev_q && (span != '0);
	assign code_done = !push_need || seg_ready;

	assign seg_valid    = (state_q == ccc_pkg::F_CODE) && push_need;
	assign seg.span_err = {8'd0, span} > (COORD_BITS + 8)'(MAX_SPAN);
	assign seg.x_major  = x_major;
	assign seg.xs_neg   = !(dx > 0);
	assign seg.ys_neg   = !(dy > 0);
	assign seg.adx      = ccc_pkg::SPAN_W'(adx);
	assign seg.ady      = ccc_pkg::SPAN_W'(ady);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccc_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ccc_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!mean_mode_q) begin
						state_d = ccc_pkg::F_CODE;
					end else if (trig) begin
						state_d = ccc_pkg::F_DIV;
					end
				end
			end
			ccc_pkg::F_DIV: begin
				if (div_last) begin
					state_d = ccc_pkg::F_CODE;
				end
			end
			ccc_pkg::F_CODE: begin
				if (code_done) begin
					state_d = ccc_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = ccc_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_mode_q <= 1'b1;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid) begin
				mean_mode_q <= cfg_data;
			end
			if (accept) begin
				if (!mean_mode_q || trig) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					cnt_q   <= '0;
				end else begin
					sum_x_q <= sum_nx;
					sum_y_q <= sum_ny;
					cnt_q   <= cnt_n;
				end
			end
			if (state_q == ccc_pkg::F_CODE && code_done) begin
				if (end_q) begin
					have_prev_q <= 1'b0;
					prev_x_q    <= '0;
					prev_y_q    <= '0;
					sum_x_q     <= '0;
					sum_y_q     <= '0;
					cnt_q       <= '0;
				end else begin
					have_prev_q <= 1'b1;
					prev_x_q    <= pt_x_q;
					prev_y_q    <= pt_y_q;
				end
			end
		end
	end

	// payload of the point in flight and the divider
	always_ff @(posedge clk) begin
		if (accept) begin
			end_q   <= end_of_contour;
			pt_x_q  <= x_coord;
			pt_y_q  <= y_coord;
			div_x_q <= sum_nx;
			div_y_q <= sum_ny;
			div_d_q <= cnt_n;
			rem_x_q <= '0;
			rem_y_q <= '0;
			it_q    <= IW'(SW);
		end else if (state_q == ccc_pkg::F_DIV) begin
			div_x_q <= div_nx;
			div_y_q <= div_ny;
			rem_x_q <= rem_nx;
			rem_y_q <= rem_ny;
			it_q    <= it_q - IW'(1);
			if (div_last) begin
				pt_x_q <= COORD_BITS'(div_nx);
				pt_y_q <= COORD_BITS'(div_ny);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ccc_seg_fifo.sv =====
// two-entry segment queue between front end and line walker
`timescale 1ns / 1ps
`default_nettype none
module ccc_seg_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire ccc_pkg::ccc_seg_t wr_seg,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output ccc_pkg::ccc_seg_t      rd_seg
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	ccc_pkg::ccc_seg_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign wr_ready = count_q != (PW + 1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_seg   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_seg;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ccc_walker.sv =====
// back end: bresenham walk of one segment, one code word per cycle while the receiver takes them
`timescale 1ns / 1ps
`default_nettype none
module ccc_walker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seg_valid,
	output logic                   seg_ready,
	input  wire ccc_pkg::ccc_seg_t seg,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             direction_code,
	output logic                   last_of_run,
	output logic                   span_error
);

	localparam int EW = ccc_pkg::LERR_W + 1;

	logic                             busy_q;
	ccc_pkg::ccc_seg_t                desc_q;
	logic signed [ccc_pkg::LERR_W-1:0] err_q;
	logic [ccc_pkg::SPAN_W-1:0]       steps_q;

	logic                 pop, fire, last;
	logic signed [EW-1:0] a2_q, b2_q, a2_in, b2_in, err_ext, err_n, err_init;
	logic                 err_ge;
	logic signed [1:0]    xs, ys, sx, sy;
	logic [2:0]           code;

	assign pop       = !busy_q && seg_valid;
	assign seg_ready = !busy_q;
	assign fire      = busy_q && (!out_valid || out_ready);
	assign last      = desc_q.span_err || (steps_q == ccc_pkg::SPAN_W'(1));

	// doubled deltas of the stored segment and of the incoming one
	assign a2_q  = signed'(EW'({desc_q.adx, 1'b0}));
	assign b2_q  = signed'(EW'({desc_q.ady, 1'b0}));
	assign a2_in = signed'(EW'({seg.adx, 1'b0}));
	assign b2_in = signed'(EW'({seg.ady, 1'b0}));
	assign err_init = seg.x_major ? b2_in - signed'(EW'(seg.adx))
	                              : a2_in - signed'(EW'(seg.ady));

	assign err_ext = EW'(err_q);
	assign err_ge  = !err_q[ccc_pkg::LERR_W-1];
	assign xs = desc_q.xs_neg ? -2'sd1 : 2'sd1;
	assign ys = desc_q.ys_neg ? -2'sd1 : 2'sd1;

	always_comb begin
		if (desc_q.x_major) begin
			sx    = xs;
			sy    = err_ge ? ys : 2'sd0;
			err_n = err_ext + b2_q - (err_ge ? a2_q : '0);
		end else begin
			sy    = ys;
			sx    = err_ge ? xs : 2'sd0;
			err_n = err_ext + a2_q - (err_ge ? b2_q : '0);
		end
		code = ccc_pkg::dir_code(sx, sy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (fire && last) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q  <= seg;
			err_q   <= ccc_pkg::LERR_W'(err_init);
			steps_q <= seg.span_err ? ccc_pkg::SPAN_W'(1)
			                        : (seg.x_major ? seg.adx : seg.ady);
		end else if (fire) begin
			err_q   <= ccc_pkg::LERR_W'(err_n);
			steps_q <= steps_q - ccc_pkg::SPAN_W'(1);
		end
		if (fire) begin
			direction_code <= desc_q.span_err ? 3'd0 : code;
			last_of_run    <= last;
			span_error     <= desc_q.span_err;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/contour_chain_coder_unit.sv =====
// top level of the contour chain coder
// Contour points enter on in_valid/in_ready (x_coord, y_coord, end_of_contour);
// Freeman direction codes leave on out_valid/out_ready, one word per code,
// last_of_run marking the final code of a point and span_error a segment
// longer than MAX_SPAN (one word, code 0). mean_mode is written on the
// cfg_valid/cfg_ready channel, which is always ready.
// The front end takes a point; a point that closes a group then passes
// through the serial divider that forms the mean before its segment is
// set up. A two-entry queue hands segments to the line walker, which
// emits one code per cycle within a segment while the receiver takes them.
// If the receiver stalls the walker holds its word; once the queue is full
// the front end stops taking points. Reset clears all contour state and
// the queue and sets mean_mode to 1.
`timescale 1ns / 1ps
`default_nettype none
module contour_chain_coder_unit #(
	parameter int COORD_BITS = ccc_pkg::COORD_BITS_DEF,
	parameter int GROUP      = ccc_pkg::GROUP_DEF,
	parameter int MAX_SPAN   = ccc_pkg::MAX_SPAN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] x_coord,
	input  wire logic [COORD_BITS-1:0] y_coord,
	input  wire logic                  end_of_contour,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 direction_code,
	output logic                       last_of_run,
	output logic                       span_error
);

	logic              f_valid, f_ready, b_valid, b_ready;
	ccc_pkg::ccc_seg_t f_seg, b_seg;

	ccc_front #(
		.COORD_BITS(COORD_BITS),
		.GROUP     (GROUP),
		.MAX_SPAN  (MAX_SPAN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.end_of_contour(end_of_contour),
		.seg_valid     (f_valid),
		.seg_ready     (f_ready),
		.seg           (f_seg)
	);

	ccc_seg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_seg  (f_seg),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_seg  (b_seg)
	);

	ccc_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.seg_valid     (b_valid),
		.seg_ready     (b_ready),
		.seg           (b_seg),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.direction_code(direction_code),
		.last_of_run   (last_of_run),
		.span_error    (span_error)
	);

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the contour chain coder: random contours checked word by word against a predictor
`timescale 1ns / 1ps
module tb_top;

	localparam int COORD_W     = 12;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	localparam int GROUP_N     = 5;
	localparam int SPAN_LIMIT  = 64;
	localparam int SETTLE      = 60;
	localparam int HOLD_AT     = 100;
	localparam int HOLD_LEN    = 400;
	localparam int MAX_REPORTS = 50;

	localparam bit MODE_RAW  = 1'b0;
	localparam bit MODE_MEAN = 1'b1;

	typedef enum logic [2:0] {
		DIR_E, DIR_SE, DIR_S, DIR_SW, DIR_W, DIR_NW, DIR_N, DIR_NE
	} freeman_dir_t;

	typedef struct {
		freeman_dir_t code;
		logic         last;
		logic         err;
	} code_word_t;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               eoc;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic end_of_contour = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] direction_code;
	logic last_of_run;
	logic span_error;

	contour_chain_coder_unit #(
		.COORD_BITS(COORD_W),
		.GROUP(GROUP_N),
		.MAX_SPAN(SPAN_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.end_of_contour(end_of_contour),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.direction_code(direction_code),
		.last_of_run(last_of_run),
		.span_error(span_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	bit mean_on = 1'b1;
	int last_x = 0, last_y = 0;
	bit have_last = 1'b0;
	int acc_x = 0, acc_y = 0, acc_n = 0;

	code_word_t pending_codes[$];
	point_t points_to_send[$];
	point_t nxt;

	int items_taken = 0;
	int contours_closed = 0;
	int words_checked = 0;
	int span_words = 0;
	int bad_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	logic [9:0] rx_tick = '0;

	function automatic freeman_dir_t freeman(input int sx, input int sy);
		if (sy == 0)
			return (sx > 0) ? DIR_E : DIR_W;
		if (sy > 0)
			return (sx > 0) ? DIR_SE : ((sx < 0) ? DIR_SW : DIR_S);
		return (sx > 0) ? DIR_NE : ((sx < 0) ? DIR_NW : DIR_N);
	endfunction

	// bresenham walk from the stored point to (tx, ty), ties step along y
	function automatic void walk_segment(input int tx, input int ty);
		int ax, ay, stx, sty, run, err, k, mx, my;
		code_word_t w;
		if (!have_last) begin
			last_x = tx;
			last_y = ty;
			have_last = 1'b1;
			return;
		end
		ax = (tx > last_x) ? tx - last_x : last_x - tx;
		ay = (ty > last_y) ? ty - last_y : last_y - ty;
		stx = (tx > last_x) ? 1 : -1;
		sty = (ty > last_y) ? 1 : -1;
		run = (ax > ay) ? ax : ay;
		last_x = tx;
		last_y = ty;
		if (run > SPAN_LIMIT) begin
			w.code = DIR_E;
			w.last = 1'b1;
			w.err = 1'b1;
			pending_codes = {pending_codes, w};
			return;
		end
		err = (ax > ay) ? 2 * ay - ax : 2 * ax - ay;
		for (k = 0; k < run; k++) begin
			if (ax > ay) begin
				mx = stx;
				my = 0;
				if (err >= 0) begin
					my = sty;
					err -= 2 * ax;
				end
				err += 2 * ay;
			end else begin
				mx = 0;
				my = sty;
				if (err >= 0) begin
					mx = stx;
					err -= 2 * ay;
				end
				err += 2 * ax;
			end
			w.code = freeman(mx, my);
			w.last = (k == run - 1);
			w.err = 1'b0;
			pending_codes = {pending_codes, w};
		end
	endfunction

	function automatic void chain_point(input int x, input int y, input bit eoc);
		if (mean_on) begin
			acc_x += x;
			acc_y += y;
			acc_n++;
			// a partial group at the end is divided by its own count
			if (acc_n >= GROUP_N || eoc) begin
				walk_segment(acc_x / acc_n, acc_y / acc_n);
				acc_x = 0;
				acc_y = 0;
				acc_n = 0;
			end
		end else begin
			acc_x = 0;
			acc_y = 0;
			acc_n = 0;
			walk_segment(x, y);
		end
		if (eoc) begin
			last_x = 0;
			last_y = 0;
			have_last = 1'b0;
			acc_x = 0;
			acc_y = 0;
			acc_n = 0;
		end
	endfunction

	// sender: bursts of words with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				chain_point(int'(x_coord), int'(y_coord), end_of_contour);
				items_taken <= items_taken + 1;
				if (end_of_contour)
					contours_closed <= contours_closed + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (points_to_send.size() != 0) begin
					nxt = points_to_send.pop_front();
					x_coord <= nxt.x;
					y_coord <= nxt.y;
					end_of_contour <= nxt.eoc;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 3) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 8);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: free-running stretches, short stall bursts, random stalls, one long hold
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && items_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (rx_tick[9:8] == 2'b11) begin
			out_ready <= 1'b1;
		end else if (rx_tick[5:3] == 3'b110) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_codes.size() == 0) begin
				bad_count <= bad_count + 1;
				if (bad_count < MAX_REPORTS)
					$display("%0t: unexpected word, got code %0d last %0b err %0b",
						$time, direction_code, last_of_run, span_error);
			end else begin
				if (direction_code !== pending_codes[0].code ||
					last_of_run !== pending_codes[0].last ||
					span_error !== pending_codes[0].err) begin
					bad_count <= bad_count + 1;
					if (bad_count < MAX_REPORTS)
						$display("%0t: expected code %0d last %0b err %0b, got code %0d last %0b err %0b",
							$time, pending_codes[0].code, pending_codes[0].last,
							pending_codes[0].err, direction_code, last_of_run, span_error);
				end
				if (pending_codes[0].err)
					span_words <= span_words + 1;
				void'(pending_codes.pop_front());
				words_checked <= words_checked + 1;
			end
		end
	end

	task automatic add_point(input int x, input int y, input bit eoc);
		point_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.eoc = eoc;
		points_to_send = {points_to_send, p};
	endtask

	// random walks with some repeats, span-boundary jumps and wild jumps;
	// the last contour of a call is left open
	task automatic add_contours(input int count, input int reach);
		int cx, cy, len, i, pick, mag;
		while (count > 0) begin
			len = $urandom_range(1, 30);
			cx = $urandom_range(0, COORD_MAX);
			cy = $urandom_range(0, COORD_MAX);
			for (i = 0; i < len && count > 0; i++) begin
				if (i != 0) begin
					pick = $urandom_range(0, 99);
					if (pick < 72) begin
						cx += int'($urandom_range(0, 2 * reach)) - reach;
						cy += int'($urandom_range(0, 2 * reach)) - reach;
					end else if (pick < 82) begin
						mag = $urandom_range(SPAN_LIMIT - 4, SPAN_LIMIT + 6);
						if ($urandom_range(0, 1))
							mag = -mag;
						if ($urandom_range(0, 1))
							cx += mag;
						else
							cy += mag;
					end else if (pick < 90) begin
						cx = $urandom_range(0, COORD_MAX);
						cy = $urandom_range(0, COORD_MAX);
					end
				end
				if (cx < 0) cx = 0;
				if (cx > COORD_MAX) cx = COORD_MAX;
				if (cy < 0) cy = 0;
				if (cy > COORD_MAX) cy = COORD_MAX;
				add_point(cx, cy, (i == len - 1) && (count > 1));
				count--;
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (points_to_send.size() != 0 || in_valid || pending_codes.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mean_on = m;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(MODE_RAW);
		add_point(100, 100, 1'b0);  // first point, no codes
		add_point(100, 100, 1'b0);  // repeated point
		add_point(103, 100, 1'b0);
		add_point(106, 103, 1'b0);  // exact diagonal
		add_point(106, 108, 1'b0);
		add_point(103, 111, 1'b0);
		add_point(98, 111, 1'b0);
		add_point(95, 108, 1'b0);
		add_point(95, 103, 1'b0);
		add_point(98, 100, 1'b0);
		add_point(105, 102, 1'b0);  // shallow mixed
		add_point(107, 109, 1'b0);  // steep mixed
		add_point(171, 109, 1'b0);  // longest legal segment
		add_point(236, 109, 1'b0);  // one step too long
		add_point(236, 44, 1'b0);
		add_point(COORD_MAX, COORD_MAX, 1'b1);
		add_point(COORD_MAX, COORD_MAX, 1'b0);
		add_point(0, 0, 1'b1);
		add_point(COORD_MAX, 0, 1'b1);  // single-point contour
		wait_drained();

		write_mode(MODE_MEAN);
		add_point(10, 10, 1'b0);
		add_point(11, 10, 1'b0);
		add_point(12, 10, 1'b0);
		add_point(13, 10, 1'b0);
		add_point(14, 10, 1'b0);
		add_point(20, 12, 1'b0);
		add_point(21, 13, 1'b1);    // partial group flushed at end
		add_contours(110, 12);
		wait_drained();

		// open contours carry across each mode change; an open group is dropped by the first raw point
		write_mode(MODE_RAW);
		add_contours(110, 40);
		wait_drained();
		write_mode(MODE_MEAN);
		add_contours(90, 12);
		wait_drained();
		write_mode(MODE_RAW);
		add_contours(74, 40);
		wait_drained();

		$display("covered %0d points in %0d closed contours, raw and averaged, with a long output hold",
			items_taken, contours_closed);
		$display("%0d code words checked, %0d span errors among them, %0d bad words",
			words_checked, span_words, bad_count);
		if (bad_count == 0)
			$display("contour_chain_coder_unit: match");
		else
			$display("contour_chain_coder_unit: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d words still expected", pending_codes.size());
		$display("contour_chain_coder_unit: mismatch");
		$finish;
	end

endmodule
